FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("plp assertion failed");

`define PLP_ASSERT_IMP(lbl, ante, cons) \
  `PLP_ASSERT(lbl, (ante) |-> (cons))

`else

`define PLP_ASSERT(lbl, prop)

`define PLP_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

FILE: sv/plp_pkg.sv
// ----------------------------------------------------------------------------
// plp_pkg
// Types and constants of the positional list insert/delete block.
// ----------------------------------------------------------------------------
package plp_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int POS_W     = 6;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 5;
  localparam int TOT_W     = 6;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                     kind;
    status_t                  status;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t                  status;
    logic                     has_element;
    logic signed [DATA_W-1:0] element;
    logic [IDX_W-1:0]         element_index;
    logic [TOT_W-1:0]         entry_total;
    logic                     last;
  } out_item_t;

endpackage

FILE: sv/plp_fifo.sv
// ----------------------------------------------------------------------------
// plp_fifo
// Small register FIFO used for the command queue and the result buffer.
// ----------------------------------------------------------------------------
module plp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             head_data,
  output logic                         not_empty,
  output logic                         full,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH-1)) ? '0 : PW'(wp_r + 1'b1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH-1)) ? '0 : PW'(rp_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (!push && pop) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  assign head_data = mem_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CW'(DEPTH));
  assign count     = cnt_r;

endmodule

FILE: sv/plp_ram.sv
// ----------------------------------------------------------------------------
// plp_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/plp_front.sv
// ----------------------------------------------------------------------------
// plp_front
// Accepts requests, checks the position against a shadow entry count and
// queues a classified command for the back end.
// ----------------------------------------------------------------------------
module plp_front #(
  parameter int DEPTH = plp_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [plp_pkg::POS_W-1:0]       position,
  input  logic signed [plp_pkg::DATA_W-1:0] value,
  input  logic                            q_full,
  output logic                            q_push,
  output plp_pkg::cmd_t                   q_cmd
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int MW = ((CW > plp_pkg::POS_W) ? CW : plp_pkg::POS_W) + 1;

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [MW-1:0]     pos_x, cnt_x;
  plp_pkg::status_t  status;

  always_comb begin
    pos_x = MW'(position);
    cnt_x = MW'(cnt_r);
    if (kind == plp_pkg::KIND_INSERT) begin
      if (pos_x == '0 || pos_x > MW'(cnt_x + MW'(1))) begin
        status = plp_pkg::ST_RANGE;
      end else if (cnt_x >= MW'(DEPTH)) begin
        status = plp_pkg::ST_FULL;
      end else begin
        status = plp_pkg::ST_DONE;
      end
    end else begin
      if (pos_x == '0 || pos_x > cnt_x) begin
        status = plp_pkg::ST_RANGE;
      end else begin
        status = plp_pkg::ST_DONE;
      end
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.kind     = kind;
    q_cmd.status   = status;
    q_cmd.position = position;
    q_cmd.value    = value;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push && status == plp_pkg::ST_DONE) begin
      cnt_nxt = (kind == plp_pkg::KIND_INSERT) ? CW'(cnt_r + 1'b1) : CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: sv/plp_back.sv
// ----------------------------------------------------------------------------
// plp_back
// Executes queued commands on the list RAM (shift, write) and streams the
// list out through a two-word result buffer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plp_back #(
  parameter int DEPTH = plp_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  plp_pkg::cmd_t       cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output plp_pkg::out_item_t  out_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);
  localparam int OB = 2;
  localparam int OW = $bits(plp_pkg::out_item_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_PUT,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  plp_pkg::cmd_t       cmd_r, cmd_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       mv_r, mv_nxt;
  logic [AW-1:0]       rd_r, rd_nxt;
  logic                wpend_r, wpend_nxt;
  logic [AW-1:0]       waddr_r, waddr_nxt;
  logic [AW-1:0]       k_r, k_nxt;
  logic                pend_r, pend_nxt;
  plp_pkg::out_item_t  tag_r, tag_nxt;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [plp_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0]       pos_c;
  logic                ins;
  logic                last_k;
  logic [$clog2(OB+1)-1:0] ob_cnt;
  logic [2:0]          ob_lvl;
  logic                issue_ok;
  logic                ob_pop, ob_full;
  plp_pkg::out_item_t  push_item;
  logic [OW-1:0]       ob_head;

  assign pos_c    = CW'(cmd.position);
  assign ins      = (cmd_r.kind == plp_pkg::KIND_INSERT);
  assign last_k   = (cnt_r == '0) || (CW'(CW'(k_r) + CW'(1)) == cnt_r);
  assign ob_pop   = out_valid && out_ready;
  assign ob_lvl   = 3'(ob_cnt) + 3'(pend_r) - 3'(ob_pop);
  assign issue_ok = (ob_lvl < 3'd2);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    mv_nxt    = mv_r;
    rd_nxt    = rd_r;
    wpend_nxt = wpend_r;
    waddr_nxt = waddr_r;
    k_nxt     = k_r;
    pend_nxt  = 1'b0;
    tag_nxt   = tag_r;
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = waddr_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = rd_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          k_nxt   = '0;
          if (cmd.status != plp_pkg::ST_DONE) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SHIFT;
            wpend_nxt = 1'b0;
            if (cmd.kind == plp_pkg::KIND_INSERT) begin
              mv_nxt  = CW'(cnt_r + CW'(1) - pos_c);
              rd_nxt  = AW'(cnt_r - CW'(1));
              cnt_nxt = CW'(cnt_r + CW'(1));
            end else begin
              mv_nxt  = CW'(cnt_r - pos_c);
              rd_nxt  = AW'(pos_c);
              cnt_nxt = CW'(cnt_r - CW'(1));
            end
          end
        end
      end
      S_SHIFT: begin
        ram_we = wpend_r;
        if (mv_r != '0) begin
          ram_re    = 1'b1;
          wpend_nxt = 1'b1;
          waddr_nxt = ins ? AW'(rd_r + 1'b1) : AW'(rd_r - 1'b1);
          rd_nxt    = ins ? AW'(rd_r - 1'b1) : AW'(rd_r + 1'b1);
          mv_nxt    = CW'(mv_r - 1'b1);
        end else begin
          wpend_nxt = 1'b0;
          state_nxt = ins ? S_PUT : S_EMIT;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cmd_r.position - plp_pkg::POS_W'(1));
        ram_wdata = cmd_r.value;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        ram_raddr = k_r;
        if (issue_ok) begin
          ram_re                = 1'b1;
          pend_nxt              = 1'b1;
          tag_nxt.status        = cmd_r.status;
          tag_nxt.has_element   = (cnt_r != '0);
          tag_nxt.element       = '0;
          tag_nxt.element_index = plp_pkg::IDX_W'(k_r);
          tag_nxt.entry_total   = plp_pkg::TOT_W'(cnt_r);
          tag_nxt.last          = last_k;
          if (last_k) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = AW'(k_r + 1'b1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      wpend_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      wpend_r <= wpend_nxt;
      pend_r  <= pend_nxt;
    end
    cmd_r   <= cmd_nxt;
    mv_r    <= mv_nxt;
    rd_r    <= rd_nxt;
    waddr_r <= waddr_nxt;
    k_r     <= k_nxt;
    tag_r   <= tag_nxt;
  end

  always_comb begin
    push_item         = tag_r;
    push_item.element = tag_r.has_element ? ram_rdata : '0;
  end

  plp_ram #(
    .WIDTH (plp_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  plp_fifo #(
    .WIDTH (OW),
    .DEPTH (OB)
  ) u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pend_r),
    .push_data (push_item),
    .pop       (ob_pop),
    .head_data (ob_head),
    .not_empty (out_valid),
    .full      (ob_full),
    .count     (ob_cnt)
  );

  assign out_item = ob_head;

  // buffer never overflows: credit check keeps pushes within room
  `PLP_ASSERT_IMP(a_obuf_room, pend_r, !ob_full || ob_pop)

endmodule

FILE: sv/positional_list_insert_delete.sv
// Sequence per request: an insert shifts the entries behind the position up and
// writes the value, a delete shifts them down, then the whole list is streamed out;
// a rejected request is only listed. The back end works on one request at a time,
// bound by the one read and one write port of the list RAM; a two-deep command queue
// buffers further requests meanwhile.
// Reset: entry count zero, queues empty; list RAM contents are not cleared.
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list with insert/delete by position; streams the list per request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_list_insert_delete #(
  parameter int DEPTH = plp_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[5:0], value[37:6]
  input  logic        in_tuser,   // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // element[31:0], element_index[36:32], entry_total[42:37]
  output logic [2:0]  out_tuser,  // status[1:0], has_element[2]
  output logic        out_tlast
);

  localparam int CQ = 2;
  localparam int QW = $bits(plp_pkg::cmd_t);

  logic               q_push, q_full, q_pop, q_valid;
  plp_pkg::cmd_t      q_in;
  logic [QW-1:0]      q_head;
  logic [$clog2(CQ+1)-1:0] q_cnt;
  plp_pkg::out_item_t item;

  plp_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .kind     (in_tuser),
    .position (in_tdata[5:0]),
    .value    (in_tdata[37:6]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  plp_fifo #(
    .WIDTH (QW),
    .DEPTH (CQ)
  ) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head_data (q_head),
    .not_empty (q_valid),
    .full      (q_full),
    .count     (q_cnt)
  );

  plp_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (item)
  );

  assign out_tdata = {5'b0, item.entry_total, item.element_index, item.element};
  assign out_tuser = {item.has_element, item.status};
  assign out_tlast = item.last;

  `PLP_ASSERT_IMP(a_empty_word, out_tvalid && !out_tuser[2],
                  out_tlast && out_tdata[42:37] == 6'd0 && out_tdata[31:0] == 32'd0)
  `PLP_ASSERT_IMP(a_last_index, out_tvalid && out_tlast && out_tuser[2],
                  out_tdata[36:32] == 5'(out_tdata[42:37] - 6'd1))
  `PLP_ASSERT_IMP(a_full_total, out_tvalid && out_tuser[1:0] == plp_pkg::ST_FULL,
                  out_tdata[42:37] == 6'(DEPTH))
  `PLP_ASSERT_IMP(a_cmdq_bound, q_pop, q_cnt != '0)

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the positional list block: insert/delete requests go in, and every
// listing word is compared against a local list kept in step with each
// accepted request. Covers empty and full lists, bad positions, and random
// traffic with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIST_DEPTH  = plp_pkg::DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // position[5:0], value[37:6]
  logic        in_tuser = 1'b0; // kind[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // element[31:0], element_index[36:32], entry_total[42:37]
  logic [2:0]  out_tuser;       // status[1:0], has_element[2]
  logic        out_tlast;

  positional_list_insert_delete uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // local copy of the list
  logic signed [plp_pkg::DATA_W-1:0] list_mem [LIST_DEPTH];
  int                                list_len = 0;
  plp_pkg::out_item_t                pending_listing [$];

  int  fail_cnt = 0;
  int  cycle_cnt = 0;
  int  ready_hold = 0;
  bit  no_idle = 1'b0;
  int  n_insert = 0;
  int  n_delete = 0;
  int  n_words = 0;
  int  peak_len = 0;
  int  status_seen [3] = '{0, 0, 0};

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycle_cnt,
               pending_listing.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side stalls
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    plp_pkg::out_item_t w;
    if (rst_n && out_tvalid && out_tready) begin
      ready_hold = no_idle ? 0 : $urandom_range(0, 6);
      if (pending_listing.size() == 0) begin
        $error("listing word with nothing pending: tdata %h tuser %h", out_tdata, out_tuser);
        fail_cnt++;
      end else begin
        w = pending_listing.pop_front();
        n_words++;
        check_field("status", w.status, out_tuser[1:0]);
        check_field("has_element", w.has_element, out_tuser[2]);
        check_field("element", w.element, $signed(out_tdata[31:0]));
        check_field("element_index", w.element_index, out_tdata[36:32]);
        check_field("entry_total", w.entry_total, out_tdata[42:37]);
        check_field("last", w.last, out_tlast);
      end
    end
  end

  // apply one request to the local list and queue the listing it produces
  function automatic void apply_list_request(logic kind, logic [plp_pkg::POS_W-1:0] pos,
                                             logic signed [plp_pkg::DATA_W-1:0] val);
    plp_pkg::status_t   st;
    plp_pkg::out_item_t w;
    int                 p;
    p = int'(pos);
    if (kind == plp_pkg::KIND_INSERT) begin
      n_insert++;
      if (p < 1 || p > list_len + 1) begin
        st = plp_pkg::ST_RANGE;
      end else if (list_len >= LIST_DEPTH) begin
        st = plp_pkg::ST_FULL;
      end else begin
        for (int i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
        list_mem[p-1] = val;
        list_len++;
        st = plp_pkg::ST_DONE;
      end
    end else begin
      n_delete++;
      if (p < 1 || p > list_len) begin
        st = plp_pkg::ST_RANGE;
      end else begin
        for (int i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
        list_len--;
        st = plp_pkg::ST_DONE;
      end
    end
    status_seen[st]++;
    if (list_len > peak_len) peak_len = list_len;
    if (list_len == 0) begin
      w = '0;
      w.status = st;
      w.last = 1'b1;
      pending_listing.push_back(w);
    end else begin
      for (int k = 0; k < list_len; k++) begin
        w.status        = st;
        w.has_element   = 1'b1;
        w.element       = list_mem[k];
        w.element_index = k[plp_pkg::IDX_W-1:0];
        w.entry_total   = list_len[plp_pkg::TOT_W-1:0];
        w.last          = (k == list_len - 1);
        pending_listing.push_back(w);
      end
    end
  endfunction

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_request(logic kind, int pos, logic signed [plp_pkg::DATA_W-1:0] val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, val, pos[plp_pkg::POS_W-1:0]};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    apply_list_request(kind, pos[plp_pkg::POS_W-1:0], val);
    @(negedge clk);
  endtask

  task automatic send_random_request(int grow_pct);
    logic                              kind;
    int                                pos;
    logic signed [plp_pkg::DATA_W-1:0] val;
    val = $urandom;
    if ($urandom_range(0, 99) < 12) begin
      kind = 1'($urandom_range(0, 1));
      pos  = $urandom_range(0, 63);
    end else if (list_len == 0 ||
                 (list_len < LIST_DEPTH && $urandom_range(0, 99) < grow_pct)) begin
      kind = plp_pkg::KIND_INSERT;
      pos  = $urandom_range(1, list_len + 1);
    end else begin
      kind = plp_pkg::KIND_DELETE;
      pos  = $urandom_range(1, list_len);
    end
    send_request(kind, pos, val);
  endtask

  task automatic test_empty_list();
    send_request(plp_pkg::KIND_DELETE, 1, 32'sd5);
    send_request(plp_pkg::KIND_INSERT, 0, 32'sd7);
    send_request(plp_pkg::KIND_INSERT, 2, 32'sd9);
    send_request(plp_pkg::KIND_DELETE, 63, -32'sd1);
    send_request(plp_pkg::KIND_INSERT, 63, 32'sd3);
  endtask

  task automatic test_positions();
    send_request(plp_pkg::KIND_INSERT, 1, 32'sh8000_0000);
    send_request(plp_pkg::KIND_INSERT, 2, 32'sh7FFF_FFFF);
    send_request(plp_pkg::KIND_INSERT, 1, -32'sd1);
    send_request(plp_pkg::KIND_INSERT, 2, 32'sd0);
    send_request(plp_pkg::KIND_INSERT, 6, 32'sd11);
    send_request(plp_pkg::KIND_DELETE, 0, 32'sd0);
    send_request(plp_pkg::KIND_DELETE, 5, 32'sd0);
    send_request(plp_pkg::KIND_DELETE, 2, 32'sd0);
    send_request(plp_pkg::KIND_DELETE, 3, 32'sd0);
    send_request(plp_pkg::KIND_DELETE, 1, 32'sd0);
    send_request(plp_pkg::KIND_INSERT, 2, 32'sh5555_AAAA);
    send_request(plp_pkg::KIND_DELETE, 1, 32'sd0);
    send_request(plp_pkg::KIND_DELETE, 1, -32'sd1);
  endtask

  task automatic test_full_list();
    while (list_len < LIST_DEPTH)
      send_request(plp_pkg::KIND_INSERT, $urandom_range(1, list_len + 1), $urandom);
    send_request(plp_pkg::KIND_INSERT, 1, 32'sd1);
    send_request(plp_pkg::KIND_INSERT, LIST_DEPTH + 1, 32'sd2);
    send_request(plp_pkg::KIND_INSERT, LIST_DEPTH + 2, 32'sd3);
    send_request(plp_pkg::KIND_INSERT, 63, 32'sd4);
    send_request(plp_pkg::KIND_DELETE, LIST_DEPTH + 1, 32'sd0);
    send_request(plp_pkg::KIND_DELETE, LIST_DEPTH, 32'sd0);
    send_request(plp_pkg::KIND_INSERT, LIST_DEPTH, -32'sd2);
    while (list_len > 0)
      send_request(plp_pkg::KIND_DELETE, $urandom_range(1, list_len), $urandom);
  endtask

  task automatic test_random_mix();
    int grow [7] = '{75, 50, 25, 90, 50, 10, 60};
    for (int ph = 0; ph < 7; ph++) begin
      no_idle = (ph == 1 || ph == 4);
      repeat (58) send_random_request(grow[ph]);
    end
    no_idle = 1'b0;
  endtask

  task automatic finish_run();
    in_tvalid <= 1'b0;
    while (pending_listing.size() != 0) @(posedge clk);
    repeat (2 * LIST_DEPTH + 16) @(posedge clk);
    if (pending_listing.size() != 0) begin
      $error("%0d listing words never arrived", pending_listing.size());
      fail_cnt++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_list();
    test_positions();
    test_full_list();
    test_random_mix();
    finish_run();
    $display("ran %0d inserts and %0d deletes, checked %0d listing words, longest list %0d",
             n_insert, n_delete, n_words, peak_len);
    $display("request outcomes: done %0d, bad position %0d, list full %0d",
             status_seen[plp_pkg::ST_DONE], status_seen[plp_pkg::ST_RANGE],
             status_seen[plp_pkg::ST_FULL]);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
